### hdl/mrc_pkg.sv
`timescale 1ns / 1ps
// mrc_pkg: shared widths, table entry type and register map for the rod cut block
// no dependencies
package mrc_pkg;

	localparam int MAX_LEN = 1023;
	localparam int LEN_W   = 10;
	localparam int CNT_W   = 10;
	localparam int DEPTH   = MAX_LEN + 1;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_LEN_A = 2'd0;
	localparam logic [1:0] REG_LEN_B = 2'd1;
	localparam logic [1:0] REG_LEN_C = 2'd2;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	// sequencer phase: one read per piece length
	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] cnt;
	} entry_t;

endpackage

### hdl/max_rod_cut_pieces.sv
`timescale 1ns / 1ps
// max_rod_cut_pieces: fills the best-count table bottom-up in one on-chip memory
// run time is set by one table read per piece length per entry (three reads per entry
// from the single read port)
// one word in flight: a new word is taken only once the last result is in the output register
// reset: arst_n asynchronous, active low; piece lengths reset to 1, table not cleared
// depends on mrc_pkg
module max_rod_cut_pieces (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mrc_pkg::PADDR_W-1:0]     paddr,
	input  logic [mrc_pkg::PDATA_W-1:0]     pwdata,
	output logic [mrc_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mrc_pkg::LEN_W-1:0]       rod_length,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            reachable,
	output logic [mrc_pkg::CNT_W-1:0]       piece_count
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                    state_q;
	logic [mrc_pkg::LEN_W-1:0]     len_a_q, len_b_q, len_c_q;
	logic [mrc_pkg::LEN_W-1:0]     len_q;
	logic [mrc_pkg::ADDR_W-1:0]    pos_q;
	logic [1:0]                    phase_q;

	mrc_pkg::entry_t               mem [mrc_pkg::DEPTH];
	mrc_pkg::entry_t               rdata_q;
	logic [mrc_pkg::ADDR_W-1:0]    raddr;
	logic [mrc_pkg::ADDR_W-1:0]    waddr;
	mrc_pkg::entry_t               wdata;
	logic                          we;

	logic                          v_s1;
	logic [1:0]                    phase_s1;
	logic [mrc_pkg::ADDR_W-1:0]    pos_s1;
	logic                          cand_s1;
	logic                          fwd_s1;
	mrc_pkg::entry_t               fwd_d_s1;

	logic                          acc_found_q;
	logic [mrc_pkg::CNT_W-1:0]     acc_best_q;
	logic                          base_found;
	logic [mrc_pkg::CNT_W-1:0]     base_best;
	logic                          new_found;
	logic [mrc_pkg::CNT_W-1:0]     new_best;
	mrc_pkg::entry_t               rd_entry;
	mrc_pkg::entry_t               new_entry;

	mrc_pkg::entry_t               res_q;

	logic [mrc_pkg::LEN_W-1:0]     sel_len;
	logic                          issue;
	logic                          cand;
	logic                          last_s1;
	logic                          cfg_wr;
	logic                          in_acc;
	logic                          out_free;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid | ~out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= mrc_pkg::LEN_RESET;
			len_b_q <= mrc_pkg::LEN_RESET;
			len_c_q <= mrc_pkg::LEN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mrc_pkg::REG_LEN_A: len_a_q <= pwdata[mrc_pkg::LEN_W-1:0];
				mrc_pkg::REG_LEN_B: len_b_q <= pwdata[mrc_pkg::LEN_W-1:0];
				mrc_pkg::REG_LEN_C: len_c_q <= pwdata[mrc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mrc_pkg::REG_LEN_A: prdata = mrc_pkg::PDATA_W'(len_a_q);
			mrc_pkg::REG_LEN_B: prdata = mrc_pkg::PDATA_W'(len_b_q);
			mrc_pkg::REG_LEN_C: prdata = mrc_pkg::PDATA_W'(len_c_q);
			default:            prdata = '0;
		endcase
	end

	// read issue
	always_comb begin
		case (phase_q)
			mrc_pkg::PH_A: sel_len = len_a_q;
			mrc_pkg::PH_B: sel_len = len_b_q;
			default:       sel_len = len_c_q;
		endcase
	end

	assign issue = (state_q == ST_RUN);
	assign raddr = pos_q - mrc_pkg::ADDR_W'(sel_len);
	assign cand  = (sel_len != '0) && (mrc_pkg::ADDR_W'(sel_len) <= pos_q);

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// read data stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= phase_q;
		pos_s1   <= pos_q;
		cand_s1  <= cand;
		fwd_s1   <= we && (waddr == raddr);
		fwd_d_s1 <= wdata;
	end

	// best-of-three merge
	assign rd_entry   = fwd_s1 ? fwd_d_s1 : rdata_q;
	assign base_found = (phase_s1 == mrc_pkg::PH_A) ? 1'b0 : acc_found_q;
	assign base_best  = (phase_s1 == mrc_pkg::PH_A) ? '0 : acc_best_q;
	assign last_s1    = v_s1 && (phase_s1 == mrc_pkg::PH_C);

	always_comb begin
		new_found = base_found;
		new_best  = base_best;
		if (cand_s1 && rd_entry.ok && (!base_found || rd_entry.cnt > base_best)) begin
			new_found = 1'b1;
			new_best  = rd_entry.cnt;
		end
		new_entry.ok  = new_found;
		new_entry.cnt = new_found ? new_best + mrc_pkg::CNT_W'(1) : '0;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_found_q <= new_found;
			acc_best_q  <= new_best;
		end
	end

	// write port: seed entry zero, then one entry per three reads
	always_comb begin
		if (state_q == ST_INIT) begin
			we        = 1'b1;
			waddr     = '0;
			wdata.ok  = 1'b1;
			wdata.cnt = '0;
		end else begin
			we    = last_s1;
			waddr = pos_s1;
			wdata = new_entry;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= mrc_pkg::PH_A;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					phase_q <= mrc_pkg::PH_A;
					pos_q   <= mrc_pkg::ADDR_W'(1);
					state_q <= (len_q == '0) ? ST_DONE : ST_RUN;
				end
				ST_RUN: begin
					if (phase_q == mrc_pkg::PH_C) begin
						phase_q <= mrc_pkg::PH_A;
						pos_q   <= pos_q + mrc_pkg::ADDR_W'(1);
						if (pos_q == mrc_pkg::ADDR_W'(len_q)) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			len_q <= rod_length;
		end
		if (state_q == ST_INIT) begin
			res_q.ok  <= 1'b1;
			res_q.cnt <= '0;
		end else if (last_s1 && pos_s1 == mrc_pkg::ADDR_W'(len_q)) begin
			res_q <= new_entry;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			reachable   <= res_q.ok;
			piece_count <= res_q.cnt;
		end
	end

endmodule

### hdl/mrc_checker.sv
`timescale 1ns / 1ps
// mrc_checker: port-level checks on the rod cut block, bound to the top level
// depends on mrc_pkg and max_rod_cut_pieces
module mrc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        reachable,
	input logic [mrc_pkg::CNT_W-1:0]   piece_count
);

	// held word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reachable) && $stable(piece_count))
		else $error("result word changed while stalled");

	// unreachable rod reports no pieces
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reachable |-> piece_count == '0)
		else $error("nonzero count on unreachable result");

	// busy after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in work");

	// a new result only appears once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while still busy");

endmodule

bind max_rod_cut_pieces mrc_checker u_mrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.reachable   (reachable),
	.piece_count (piece_count)
);
